// ----- sv/mse_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, opcodes and constants of the MIPS subset executor.
// Used by the core, mse_dmem and mse_alu; depends on nothing.
package mse_pkg;

  localparam int unsigned DataBytes = 8192;
  localparam logic [31:0] TextBaseReset = 32'h0040_0000;
  localparam logic [31:0] DataBaseReset = 32'h1001_0000;
  localparam logic [31:0] JumpRegionMask = 32'hf000_0000;

  localparam logic [4:0] RegV0 = 5'd2;
  localparam logic [4:0] RegA0 = 5'd4;
  localparam logic [4:0] RegRa = 5'd31;

  localparam logic [5:0] OpSpecial = 6'd0;
  localparam logic [5:0] OpJ = 6'd2;
  localparam logic [5:0] OpJal = 6'd3;
  localparam logic [5:0] OpBeq = 6'd4;
  localparam logic [5:0] OpBne = 6'd5;
  localparam logic [5:0] OpAddi = 6'd8;
  localparam logic [5:0] OpAddiu = 6'd9;
  localparam logic [5:0] OpSlti = 6'd10;
  localparam logic [5:0] OpAndi = 6'd12;
  localparam logic [5:0] OpOri = 6'd13;
  localparam logic [5:0] OpXori = 6'd14;
  localparam logic [5:0] OpLui = 6'd15;
  localparam logic [5:0] OpLb = 6'd32;
  localparam logic [5:0] OpLh = 6'd33;
  localparam logic [5:0] OpLw = 6'd35;
  localparam logic [5:0] OpSb = 6'd40;
  localparam logic [5:0] OpSh = 6'd41;
  localparam logic [5:0] OpSw = 6'd43;

  localparam logic [5:0] FnSll = 6'h00;
  localparam logic [5:0] FnSrl = 6'h02;
  localparam logic [5:0] FnJr = 6'h08;
  localparam logic [5:0] FnSyscall = 6'h0c;
  localparam logic [5:0] FnAdd = 6'h20;
  localparam logic [5:0] FnAddu = 6'h21;
  localparam logic [5:0] FnSub = 6'h22;
  localparam logic [5:0] FnAnd = 6'h24;
  localparam logic [5:0] FnOr = 6'h25;
  localparam logic [5:0] FnXor = 6'h26;
  localparam logic [5:0] FnSlt = 6'h2a;

  localparam logic [31:0] SvcPrintInt = 32'd1;
  localparam logic [31:0] SvcReadInt = 32'd5;
  localparam logic [31:0] SvcPrintChar = 32'd11;
  localparam logic [31:0] SvcReadChar = 32'd12;

  localparam logic [7:0] CfgTextBase = 8'd0;
  localparam logic [7:0] CfgDataBase = 8'd1;

  typedef enum logic [1:0] {
    StatusOk = 2'd0,
    StatusUnknown = 2'd1,
    StatusAddr = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    PrintNone = 2'd0,
    PrintInt = 2'd1,
    PrintChar = 2'd2
  } print_e;

  typedef struct packed {
    logic        wb_en;
    logic [4:0]  wb_addr;
    logic [31:0] wb_data;
    logic [31:0] npc;
    print_e      kind;
    logic [31:0] pval;
    status_e     status;
    logic        mem_rd;
    logic        mem_wr;
    logic [2:0]  size;
    logic [31:0] off;
    logic [31:0] st_data;
    logic [4:0]  ld_rt;
  } ex_res_t;

  function automatic logic is_syscall(logic [31:0] instr);
    is_syscall = (instr[31:26] == OpSpecial) && (instr[5:0] == FnSyscall);
  endfunction

endpackage

// ----- sv/mips_subset_instruction_executor_core.sv -----
`timescale 1ns / 1ps
// Top level of the MIPS subset executor: handshakes, PC, pipeline control.
// Depends on mse_pkg, mse_regfile, mse_dmem and mse_alu.

// Each transaction carries one instruction and yields one result. Operands
// are read from the register file in the accept cycle and the instruction
// executes once the result register can take it; a new instruction is
// taken every cycle unless results stall, except that a load holds the input
// while it executes, as its bytes come back from the data memory. The
// result register lets the next instruction enter while a result waits.
// Data memory contents are undefined until written.
module mips_subset_instruction_executor_core #(
  parameter int unsigned DATA_BYTES = mse_pkg::DataBytes
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] instruction_i,
  input  logic signed [31:0] read_value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] executed_pc_o,
  output logic [31:0] next_pc_o,
  output logic [1:0]  print_kind_o,
  output logic signed [31:0] print_value_o,
  output logic [1:0]  status_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  localparam int unsigned OW = $clog2(DATA_BYTES);

  logic [31:0] data_base_q;
  logic [31:0] pc_q, pc_d;
  logic        ex_v_q;
  logic [31:0] ex_instr_q;
  logic [31:0] ex_rv_q;
  logic        wb_v_q;
  logic [4:0]  wb_rt_q;
  logic [2:0]  wb_size_q;
  logic        out_v_q;
  logic [31:0] out_pc_q, out_npc_q, out_pval_q;
  logic [1:0]  out_kind_q, out_status_q;

  logic        accept, ex_go, cfg_wr;
  logic [4:0]  raddr_a, raddr_b;
  logic [31:0] a, b, ld_word, ld_val;
  logic        rf_we;
  logic [4:0]  rf_waddr;
  logic [31:0] rf_wdata;
  mse_pkg::ex_res_t res;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr = cfg_valid_i;
  assign ex_go = ex_v_q && (!out_v_q || out_ready_i);
  assign in_ready_o = (!ex_v_q || ex_go) && !(ex_v_q && res.mem_rd);
  assign accept = in_valid_i && in_ready_o;

  assign raddr_a = mse_pkg::is_syscall(instruction_i) ? mse_pkg::RegV0
                                                       : instruction_i[25:21];
  assign raddr_b = mse_pkg::is_syscall(instruction_i) ? mse_pkg::RegA0
                                                       : instruction_i[20:16];

  always_comb begin
    unique case (wb_size_q)
      3'd1: ld_val = {{24{ld_word[7]}}, ld_word[7:0]};
      3'd2: ld_val = {{16{ld_word[15]}}, ld_word[15:0]};
      default: ld_val = ld_word;
    endcase
  end

  always_comb begin
    if (wb_v_q) begin
      rf_we = 1'b1;
      rf_waddr = wb_rt_q;
      rf_wdata = ld_val;
    end else begin
      rf_we = ex_go && res.wb_en;
      rf_waddr = res.wb_addr;
      rf_wdata = res.wb_data;
    end
  end

  mse_regfile u_regfile (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .re_i      (accept),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (a),
    .rdata_b_o (b),
    .we_i      (rf_we),
    .waddr_i   (rf_waddr),
    .wdata_i   (rf_wdata)
  );

  mse_alu #(
    .DATA_BYTES (DATA_BYTES)
  ) u_alu (
    .instr_i      (ex_instr_q),
    .pc_i         (pc_q),
    .a_i          (a),
    .b_i          (b),
    .read_value_i (ex_rv_q),
    .data_base_i  (data_base_q),
    .res_o        (res)
  );

  mse_dmem #(
    .DATA_BYTES (DATA_BYTES)
  ) u_dmem (
    .clk_i   (clk_i),
    .rd_en_i (ex_go && res.mem_rd),
    .wr_en_i (ex_go && res.mem_wr),
    .off_i   (res.off[OW-1:0]),
    .size_i  (res.size),
    .wdata_i (res.st_data),
    .rdata_o (ld_word)
  );

  always_comb begin
    pc_d = pc_q;
    if (cfg_wr && (cfg_index_i == mse_pkg::CfgTextBase)) begin
      pc_d = cfg_data_i;
    end else if (ex_go) begin
      pc_d = res.npc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_base_q <= mse_pkg::DataBaseReset;
      pc_q <= mse_pkg::TextBaseReset;
      ex_v_q <= 1'b0;
      wb_v_q <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      pc_q <= pc_d;
      if (cfg_wr && (cfg_index_i == mse_pkg::CfgDataBase)) begin
        data_base_q <= cfg_data_i;
      end
      if (accept) begin
        ex_v_q <= 1'b1;
      end else if (ex_go) begin
        ex_v_q <= 1'b0;
      end
      wb_v_q <= ex_go && res.mem_rd;
      if (ex_go) begin
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ex_instr_q <= instruction_i;
      ex_rv_q <= read_value_i;
    end
    if (ex_go) begin
      wb_rt_q <= res.ld_rt;
      wb_size_q <= res.size;
      out_pc_q <= pc_q;
      out_npc_q <= res.npc;
      out_kind_q <= res.kind;
      out_pval_q <= res.pval;
      out_status_q <= res.status;
    end
  end

  assign out_valid_o = out_v_q;
  assign executed_pc_o = out_pc_q;
  assign next_pc_o = out_npc_q;
  assign print_kind_o = out_kind_q;
  assign print_value_o = out_pval_q;
  assign status_o = out_status_q;

  a_single_rf_write : assert property (@(posedge clk_i) disable iff (!rst_ni)
    wb_v_q |-> !(ex_go && res.wb_en)) else $error("two register writes in one cycle");

  a_load_to_wb : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ex_go && res.mem_rd) |=> wb_v_q) else $error("load data not written back");

  a_accept_fills_ex : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> ex_v_q) else $error("accepted instruction lost");

  a_bad_status_no_mem : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ex_v_q && (res.status != mse_pkg::StatusOk)) |-> !(res.mem_rd || res.mem_wr))
    else $error("memory access despite error status");

endmodule

// ----- sv/mse_regfile.sv -----
`timescale 1ns / 1ps
// Register file: 32 x 32 synchronous memory with two registered read ports.
// Valid bits give the all-zero reset; depends on nothing else.
module mse_regfile (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        re_i,
  input  logic [4:0]  raddr_a_i,
  input  logic [4:0]  raddr_b_i,
  output logic [31:0] rdata_a_o,
  output logic [31:0] rdata_b_o,
  input  logic        we_i,
  input  logic [4:0]  waddr_i,
  input  logic [31:0] wdata_i
);

  logic [31:0] mem [32];
  logic [31:0] vld_q;
  logic [31:0] rdata_a_q;
  logic [31:0] rdata_b_q;
  logic        wr;

  assign wr = we_i && (waddr_i != 5'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (wr) begin
      vld_q[waddr_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      if (wr && (waddr_i == raddr_a_i)) begin
        rdata_a_q <= wdata_i;
      end else begin
        rdata_a_q <= vld_q[raddr_a_i] ? mem[raddr_a_i] : 32'd0;
      end
      if (wr && (waddr_i == raddr_b_i)) begin
        rdata_b_q <= wdata_i;
      end else begin
        rdata_b_q <= vld_q[raddr_b_i] ? mem[raddr_b_i] : 32'd0;
      end
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

// ----- sv/mse_dmem.sv -----
`timescale 1ns / 1ps
// Data memory: four byte banks with registered reads, giving
// unaligned little-endian access of up to four bytes; depends on mse_pkg.
module mse_dmem #(
  parameter int unsigned DATA_BYTES = mse_pkg::DataBytes
) (
  input  logic                          clk_i,
  input  logic                          rd_en_i,
  input  logic                          wr_en_i,
  input  logic [$clog2(DATA_BYTES)-1:0] off_i,
  input  logic [2:0]                    size_i,
  input  logic [31:0]                   wdata_i,
  output logic [31:0]                   rdata_o
);

  localparam int unsigned OW = $clog2(DATA_BYTES);
  localparam int unsigned Rows = (DATA_BYTES + 3) / 4;

  logic [1:0]  lo_q;
  logic [7:0]  bank_q [4];

  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [7:0]    mem [Rows];
    logic [1:0]    j;
    logic [OW-1:0] addr;
    logic          en;

    assign j = 2'(b) - off_i[1:0];
    assign addr = off_i + OW'(j);
    assign en = {1'b0, j} < size_i;

    always_ff @(posedge clk_i) begin
      if (wr_en_i && en) begin
        mem[addr[OW-1:2]] <= wdata_i[8*j +: 8];
      end
      if (rd_en_i) begin
        bank_q[b] <= mem[addr[OW-1:2]];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      lo_q <= off_i[1:0];
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      rdata_o[8*i +: 8] = bank_q[2'(lo_q + 2'(i))];
    end
  end

endmodule

// ----- sv/mse_alu.sv -----
`timescale 1ns / 1ps
// Execute logic: decodes one instruction and computes write-back, next PC,
// syscall output, status and the data memory request; depends on mse_pkg.
module mse_alu #(
  parameter int unsigned DATA_BYTES = mse_pkg::DataBytes
) (
  input  logic [31:0]     instr_i,
  input  logic [31:0]     pc_i,
  input  logic [31:0]     a_i,
  input  logic [31:0]     b_i,
  input  logic [31:0]     read_value_i,
  input  logic [31:0]     data_base_i,
  output mse_pkg::ex_res_t res_o
);

  logic [5:0]  op;
  logic [5:0]  fn;
  logic [4:0]  rt;
  logic [4:0]  rd;
  logic [4:0]  sh;
  logic [31:0] imm;
  logic [31:0] simm;
  logic [31:0] pc4;
  logic [31:0] off;
  logic        in_range;

  assign op = instr_i[31:26];
  assign fn = instr_i[5:0];
  assign rt = instr_i[20:16];
  assign rd = instr_i[15:11];
  assign sh = instr_i[10:6];
  assign imm = {16'd0, instr_i[15:0]};
  assign simm = {{16{instr_i[15]}}, instr_i[15:0]};
  assign pc4 = pc_i + 32'd4;
  assign off = a_i + simm - data_base_i;

  always_comb begin
    res_o = '0;
    res_o.npc = pc4;
    res_o.kind = mse_pkg::PrintNone;
    res_o.status = mse_pkg::StatusOk;
    res_o.wb_addr = rt;
    res_o.off = off;
    res_o.st_data = b_i;
    res_o.ld_rt = rt;
    in_range = 1'b0;
    if (op == mse_pkg::OpSpecial) begin
      res_o.wb_addr = rd;
      unique case (fn)
        mse_pkg::FnAdd, mse_pkg::FnAddu: begin
          res_o.wb_en = 1'b1;
          res_o.wb_data = a_i + b_i;
        end
        mse_pkg::FnSub: begin
          res_o.wb_en = 1'b1;
          res_o.wb_data = a_i - b_i;
        end
        mse_pkg::FnAnd: begin
          res_o.wb_en = 1'b1;
          res_o.wb_data = a_i & b_i;
        end
        mse_pkg::FnOr: begin
          res_o.wb_en = 1'b1;
          res_o.wb_data = a_i | b_i;
        end
        mse_pkg::FnXor: begin
          res_o.wb_en = 1'b1;
          res_o.wb_data = a_i ^ b_i;
        end
        mse_pkg::FnSlt: begin
          res_o.wb_en = 1'b1;
          res_o.wb_data = {31'd0, $signed(a_i) < $signed(b_i)};
        end
        mse_pkg::FnSll: begin
          res_o.wb_en = 1'b1;
          res_o.wb_data = b_i << sh;
        end
        mse_pkg::FnSrl: begin
          res_o.wb_en = 1'b1;
          res_o.wb_data = b_i >> sh;
        end
        mse_pkg::FnJr: begin
          res_o.npc = a_i;
        end
        mse_pkg::FnSyscall: begin
          res_o.wb_addr = mse_pkg::RegV0;
          res_o.wb_data = read_value_i;
          unique case (a_i)
            mse_pkg::SvcPrintInt: begin
              res_o.kind = mse_pkg::PrintInt;
              res_o.pval = b_i;
            end
            mse_pkg::SvcPrintChar: begin
              res_o.kind = mse_pkg::PrintChar;
              res_o.pval = b_i;
            end
            mse_pkg::SvcReadInt, mse_pkg::SvcReadChar: begin
              res_o.wb_en = 1'b1;
            end
            default: begin
            end
          endcase
        end
        default: begin
          res_o.status = mse_pkg::StatusUnknown;
        end
      endcase
    end else begin
      unique case (op)
        mse_pkg::OpJ: begin
          res_o.npc = (pc4 & mse_pkg::JumpRegionMask) | {4'd0, instr_i[25:0], 2'b00};
        end
        mse_pkg::OpJal: begin
          res_o.wb_en = 1'b1;
          res_o.wb_addr = mse_pkg::RegRa;
          res_o.wb_data = pc4;
          res_o.npc = (pc4 & mse_pkg::JumpRegionMask) | {4'd0, instr_i[25:0], 2'b00};
        end
        mse_pkg::OpAddi, mse_pkg::OpAddiu: begin
          res_o.wb_en = 1'b1;
          res_o.wb_data = a_i + simm;
        end
        mse_pkg::OpSlti: begin
          res_o.wb_en = 1'b1;
          res_o.wb_data = {31'd0, $signed(a_i) < $signed(simm)};
        end
        mse_pkg::OpAndi: begin
          res_o.wb_en = 1'b1;
          res_o.wb_data = a_i & imm;
        end
        mse_pkg::OpOri: begin
          res_o.wb_en = 1'b1;
          res_o.wb_data = a_i | imm;
        end
        mse_pkg::OpXori: begin
          res_o.wb_en = 1'b1;
          res_o.wb_data = a_i ^ imm;
        end
        mse_pkg::OpLui: begin
          res_o.wb_en = 1'b1;
          res_o.wb_data = imm << 16;
        end
        mse_pkg::OpBeq: begin
          if (a_i == b_i) begin
            res_o.npc = pc4 + (simm << 2);
          end
        end
        mse_pkg::OpBne: begin
          if (a_i != b_i) begin
            res_o.npc = pc4 + (simm << 2);
          end
        end
        mse_pkg::OpLb, mse_pkg::OpSb: res_o.size = 3'd1;
        mse_pkg::OpLh, mse_pkg::OpSh: res_o.size = 3'd2;
        mse_pkg::OpLw, mse_pkg::OpSw: res_o.size = 3'd4;
        default: begin
          res_o.status = mse_pkg::StatusUnknown;
        end
      endcase
      if (res_o.size != 3'd0) begin
        in_range = ({1'b0, off} + 33'(res_o.size)) <= 33'(DATA_BYTES);
        if (!in_range) begin
          res_o.status = mse_pkg::StatusAddr;
        end else if (op[3]) begin
          res_o.mem_wr = 1'b1;
        end else begin
          res_o.mem_rd = 1'b1;
        end
      end
    end
  end

endmodule

// ----- test/mse_checker.sv -----
`timescale 1ns / 1ps
// Checker for the MIPS subset executor: watches the instruction, result and
// configuration channels, predicts every result and compares it field by field.
// Depends on mse_pkg.
module mse_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [31:0] instruction_i,
  input  logic [31:0] read_value_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [31:0] executed_pc_i,
  input  logic [31:0] next_pc_i,
  input  logic [1:0]  print_kind_i,
  input  logic [31:0] print_value_i,
  input  logic [1:0]  status_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [7:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          results_o
);

  typedef struct packed {
    logic [31:0] exec_pc;
    logic [31:0] next_pc;
    logic [1:0]  kind;
    logic [31:0] pval;
    logic [1:0]  status;
  } outcome_t;

  outcome_t    outcome_q[$];
  logic [31:0] gpr[32];
  logic [31:0] pc_m;
  logic [31:0] text_base_m;
  logic [31:0] data_base_m;
  logic [7:0]  mem_m[mse_pkg::DataBytes];

  initial begin
    fail_count_o = 0;
    pending_o = 0;
    results_o = 0;
  end

  task automatic report(input string field, input logic [31:0] got, input logic [31:0] want);
    if (fail_count_o < 40) begin
      $display("[%0t] mismatch on %s: got %h, expected %h", $realtime, field, got, want);
    end
    fail_count_o++;
  endtask

  function automatic void set_gpr(input logic [4:0] idx, input logic [31:0] v);
    if (idx != 5'd0) gpr[idx] = v;
  endfunction

  function automatic outcome_t execute(input logic [31:0] w, input logic [31:0] rv);
    outcome_t    o;
    logic [5:0]  op;
    logic [5:0]  fn;
    logic [4:0]  rs;
    logic [4:0]  rt;
    logic [4:0]  rd;
    logic [4:0]  sh;
    logic [31:0] imm;
    logic [31:0] simm;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] npc;
    logic [31:0] off;
    logic [31:0] ld;
    int          size;
    op = w[31:26];
    fn = w[5:0];
    rs = w[25:21];
    rt = w[20:16];
    rd = w[15:11];
    sh = w[10:6];
    imm = {16'b0, w[15:0]};
    simm = {{16{w[15]}}, w[15:0]};
    a = gpr[rs];
    b = gpr[rt];
    npc = pc_m + 32'd4;
    size = 0;
    o.exec_pc = pc_m;
    o.kind = mse_pkg::PrintNone;
    o.pval = '0;
    o.status = mse_pkg::StatusOk;
    if (op == mse_pkg::OpSpecial) begin
      case (fn)
        mse_pkg::FnAdd, mse_pkg::FnAddu: set_gpr(rd, a + b);
        mse_pkg::FnSub: set_gpr(rd, a - b);
        mse_pkg::FnAnd: set_gpr(rd, a & b);
        mse_pkg::FnOr: set_gpr(rd, a | b);
        mse_pkg::FnXor: set_gpr(rd, a ^ b);
        mse_pkg::FnSlt: set_gpr(rd, {31'b0, $signed(a) < $signed(b)});
        mse_pkg::FnSll: set_gpr(rd, b << sh);
        mse_pkg::FnSrl: set_gpr(rd, b >> sh);
        mse_pkg::FnJr: npc = a;
        mse_pkg::FnSyscall: begin
          if (gpr[mse_pkg::RegV0] == mse_pkg::SvcPrintInt) begin
            o.kind = mse_pkg::PrintInt;
            o.pval = gpr[mse_pkg::RegA0];
          end else if (gpr[mse_pkg::RegV0] == mse_pkg::SvcPrintChar) begin
            o.kind = mse_pkg::PrintChar;
            o.pval = gpr[mse_pkg::RegA0];
          end else if (gpr[mse_pkg::RegV0] == mse_pkg::SvcReadInt ||
                       gpr[mse_pkg::RegV0] == mse_pkg::SvcReadChar) begin
            set_gpr(mse_pkg::RegV0, rv);
          end
        end
        default: o.status = mse_pkg::StatusUnknown;
      endcase
    end else if (op == mse_pkg::OpJ || op == mse_pkg::OpJal) begin
      if (op == mse_pkg::OpJal) set_gpr(mse_pkg::RegRa, pc_m + 32'd4);
      npc = ((pc_m + 32'd4) & mse_pkg::JumpRegionMask) | {4'b0, w[25:0], 2'b00};
    end else begin
      case (op)
        mse_pkg::OpAddi, mse_pkg::OpAddiu: set_gpr(rt, a + simm);
        mse_pkg::OpSlti: set_gpr(rt, {31'b0, $signed(a) < $signed(simm)});
        mse_pkg::OpAndi: set_gpr(rt, a & imm);
        mse_pkg::OpOri: set_gpr(rt, a | imm);
        mse_pkg::OpXori: set_gpr(rt, a ^ imm);
        mse_pkg::OpLui: set_gpr(rt, {w[15:0], 16'b0});
        mse_pkg::OpBeq: if (a == b) npc = pc_m + 32'd4 + (simm << 2);
        mse_pkg::OpBne: if (a != b) npc = pc_m + 32'd4 + (simm << 2);
        mse_pkg::OpLb, mse_pkg::OpSb: size = 1;
        mse_pkg::OpLh, mse_pkg::OpSh: size = 2;
        mse_pkg::OpLw, mse_pkg::OpSw: size = 4;
        default: o.status = mse_pkg::StatusUnknown;
      endcase
      if (size != 0) begin
        off = a + simm - data_base_m;
        if ({32'b0, off} + 64'(size) > 64'(mse_pkg::DataBytes)) begin
          o.status = mse_pkg::StatusAddr;
        end else if (op == mse_pkg::OpSb || op == mse_pkg::OpSh || op == mse_pkg::OpSw) begin
          for (int i = 0; i < size; i++) mem_m[off + i] = b[8*i +: 8];
        end else begin
          ld = '0;
          for (int i = 0; i < size; i++) ld[8*i +: 8] = mem_m[off + i];
          if (size == 1) ld = {{24{ld[7]}}, ld[7:0]};
          else if (size == 2) ld = {{16{ld[15]}}, ld[15:0]};
          set_gpr(rt, ld);
        end
      end
    end
    pc_m = npc;
    o.next_pc = npc;
    return o;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    outcome_t want;
    if (!rst_ni) begin
      text_base_m = mse_pkg::TextBaseReset;
      data_base_m = mse_pkg::DataBaseReset;
      pc_m = mse_pkg::TextBaseReset;
      for (int i = 0; i < 32; i++) gpr[i] = '0;
      outcome_q.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        results_o++;
        if (outcome_q.size() == 0) begin
          report("unexpected result", executed_pc_i, 32'h0);
        end else begin
          want = outcome_q.pop_front();
          if (executed_pc_i !== want.exec_pc) report("executed_pc", executed_pc_i, want.exec_pc);
          if (next_pc_i !== want.next_pc) report("next_pc", next_pc_i, want.next_pc);
          if (print_kind_i !== want.kind) begin
            report("print_kind", 32'(print_kind_i), 32'(want.kind));
          end
          if (print_value_i !== want.pval) report("print_value", print_value_i, want.pval);
          if (status_i !== want.status) report("status", 32'(status_i), 32'(want.status));
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == mse_pkg::CfgTextBase) begin
          text_base_m = cfg_data_i;
          pc_m = cfg_data_i;
        end else if (cfg_index_i == mse_pkg::CfgDataBase) begin
          data_base_m = cfg_data_i;
        end
      end
      if (in_valid_i && in_ready_i) outcome_q.push_back(execute(instruction_i, read_value_i));
    end
    pending_o = outcome_q.size();
  end

  final begin
    if (outcome_q.size() != 0) $display("%0d results never arrived", outcome_q.size());
  end

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
// Top of the MIPS subset executor testbench: clock, reset, instruction and
// configuration stimulus, result back-pressure and the verdict.
// Depends on mse_pkg, mse_checker and mips_subset_instruction_executor_core.
module testbench;

  localparam logic [4:0] BaseReg = 5'd23;
  localparam logic [7:0] CfgUnused = 8'd200;
  localparam logic [5:0] OpGap = 6'd11;
  localparam logic [5:0] OpUnusedTop = 6'h3f;

  logic        clk_i = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] instr = '0;
  logic [31:0] rd_val = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] executed_pc;
  logic [31:0] next_pc;
  logic [1:0]  print_kind;
  logic [31:0] print_value;
  logic [1:0]  status;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  int          fail_count;
  int          pending;
  int          results;
  logic        calm = 1'b0;
  logic        hold_req = 1'b0;
  int          settings_run = 0;

  mips_subset_instruction_executor_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .instruction_i (instr),
    .read_value_i  (rd_val),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .executed_pc_o (executed_pc),
    .next_pc_o     (next_pc),
    .print_kind_o  (print_kind),
    .print_value_o (print_value),
    .status_o      (status),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  mse_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .instruction_i (instr),
    .read_value_i  (rd_val),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .executed_pc_i (executed_pc),
    .next_pc_i     (next_pc),
    .print_kind_i  (print_kind),
    .print_value_i (print_value),
    .status_i      (status),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_i   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .results_o     (results)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2ms;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic logic [31:0] rtype(input logic [4:0] rs, input logic [4:0] rt,
                                        input logic [4:0] rd, input logic [4:0] sh,
                                        input logic [5:0] fn);
    return {mse_pkg::OpSpecial, rs, rt, rd, sh, fn};
  endfunction

  function automatic logic [31:0] itype(input logic [5:0] op, input logic [4:0] rs,
                                        input logic [4:0] rt, input logic [15:0] imm);
    return {op, rs, rt, imm};
  endfunction

  function automatic bit known_op(input logic [5:0] op);
    return op == mse_pkg::OpSpecial || op == mse_pkg::OpJ || op == mse_pkg::OpJal ||
           op == mse_pkg::OpBeq || op == mse_pkg::OpBne ||
           (op >= mse_pkg::OpAddi && op <= mse_pkg::OpLui && op != OpGap) ||
           op == mse_pkg::OpLb || op == mse_pkg::OpLh || op == mse_pkg::OpLw ||
           op == mse_pkg::OpSb || op == mse_pkg::OpSh || op == mse_pkg::OpSw;
  endfunction

  function automatic bit known_fn(input logic [5:0] fn);
    return fn == mse_pkg::FnSll || fn == mse_pkg::FnSrl || fn == mse_pkg::FnJr ||
           fn == mse_pkg::FnSyscall || fn == mse_pkg::FnAdd || fn == mse_pkg::FnAddu ||
           fn == mse_pkg::FnSub || fn == mse_pkg::FnAnd || fn == mse_pkg::FnOr ||
           fn == mse_pkg::FnXor || fn == mse_pkg::FnSlt;
  endfunction

  // The base register must keep pointing at data memory byte zero, and a load
  // may only read the initialized window at the bottom of memory.
  function automatic logic [31:0] sanitize(input logic [31:0] w);
    logic [5:0] op;
    int         size;
    op = w[31:26];
    size = (op == mse_pkg::OpLb) ? 1 : (op == mse_pkg::OpLh) ? 2 :
           (op == mse_pkg::OpLw) ? 4 : 0;
    if (op == mse_pkg::OpSpecial && w[15:11] == BaseReg) w[15:11] = BaseReg + 5'd1;
    if (((op >= mse_pkg::OpAddi && op <= mse_pkg::OpLui) || size != 0) &&
        w[20:16] == BaseReg) begin
      w[20:16] = BaseReg + 5'd1;
    end
    if (size != 0) begin
      w[25:21] = BaseReg;
      if (!w[15] && int'(w[15:0]) > 256 - size &&
          int'(w[15:0]) + size <= mse_pkg::DataBytes) begin
        w[15:0] = {8'b0, w[7:2], 2'b00} & 16'h00fc;
      end
    end
    return w;
  endfunction

  task automatic issue(input logic [31:0] w, input logic [31:0] rv);
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    instr <= w;
    rd_val <= rv;
    do @(posedge clk_i); while (!in_ready);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    wait (pending == 0);
    @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [7:0] idx, input logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic point_base(input logic [31:0] value);
    issue(itype(mse_pkg::OpLui, 5'd0, BaseReg, value[31:16]), $urandom);
    issue(itype(mse_pkg::OpOri, BaseReg, BaseReg, value[15:0]), $urandom);
  endtask

  task automatic random_op();
    int          sel;
    int          size;
    logic [31:0] w;
    logic [5:0]  op;
    logic [5:0]  fn;
    logic [4:0]  rs;
    logic [4:0]  rt;
    logic [15:0] imm;
    sel = $urandom_range(0, 99);
    rs = 5'($urandom);
    rt = 5'($urandom);
    imm = 16'($urandom);
    w = $urandom;
    if (sel < 22) begin
      case ($urandom_range(0, 7))
        0: fn = mse_pkg::FnAdd;
        1: fn = mse_pkg::FnAddu;
        2: fn = mse_pkg::FnSub;
        3: fn = mse_pkg::FnAnd;
        4: fn = mse_pkg::FnOr;
        5: fn = mse_pkg::FnXor;
        default: fn = mse_pkg::FnSlt;
      endcase
      w = rtype(rs, rt, w[15:11], w[10:6], fn);
    end else if (sel < 30) begin
      w = rtype(rs, rt, w[15:11], w[10:6],
                $urandom_range(0, 1) ? mse_pkg::FnSll : mse_pkg::FnSrl);
    end else if (sel < 48) begin
      case ($urandom_range(0, 7))
        0: op = mse_pkg::OpAddi;
        1: op = mse_pkg::OpAddiu;
        2: op = mse_pkg::OpSlti;
        3: op = mse_pkg::OpAndi;
        4: op = mse_pkg::OpOri;
        5: op = mse_pkg::OpXori;
        default: op = mse_pkg::OpLui;
      endcase
      w = itype(op, rs, rt, imm);
    end else if (sel < 56) begin
      if ($urandom_range(0, 2) == 0) rt = rs;
      w = itype($urandom_range(0, 1) ? mse_pkg::OpBeq : mse_pkg::OpBne, rs, rt, imm);
    end else if (sel < 60) begin
      w[31:26] = $urandom_range(0, 1) ? mse_pkg::OpJ : mse_pkg::OpJal;
    end else if (sel < 62) begin
      w = rtype(rs, w[20:16], w[15:11], w[10:6], mse_pkg::FnJr);
    end else if (sel < 70) begin
      case ($urandom_range(0, 4))
        0: imm = mse_pkg::SvcPrintInt[15:0];
        1: imm = mse_pkg::SvcPrintChar[15:0];
        2: imm = mse_pkg::SvcReadInt[15:0];
        3: imm = mse_pkg::SvcReadChar[15:0];
        default: imm = 16'($urandom);
      endcase
      issue(itype(mse_pkg::OpAddiu, 5'd0, mse_pkg::RegV0, imm), $urandom);
      w[31:26] = mse_pkg::OpSpecial;
      w[5:0] = mse_pkg::FnSyscall;
    end else if (sel < 80) begin
      case ($urandom_range(0, 2))
        0: begin op = mse_pkg::OpLb; size = 1; end
        1: begin op = mse_pkg::OpLh; size = 2; end
        default: begin op = mse_pkg::OpLw; size = 4; end
      endcase
      case ($urandom_range(0, 9))
        0: imm = 16'($urandom_range(16'h8000, 16'hffff));
        1: imm = 16'(mse_pkg::DataBytes - size + $urandom_range(1, 3));
        default: imm = 16'($urandom_range(0, 256 - size));
      endcase
      w = itype(op, BaseReg, rt, imm);
    end else if (sel < 90) begin
      case ($urandom_range(0, 2))
        0: begin op = mse_pkg::OpSb; size = 1; end
        1: begin op = mse_pkg::OpSh; size = 2; end
        default: begin op = mse_pkg::OpSw; size = 4; end
      endcase
      if ($urandom_range(0, 3) != 0) begin
        rs = BaseReg;
        imm = $urandom_range(0, 9) == 0 ? imm
                                        : 16'($urandom_range(0, mse_pkg::DataBytes - size));
      end
      w = itype(op, rs, rt, imm);
    end else if (sel < 95) begin
      if ($urandom_range(0, 1) == 0) begin
        do fn = 6'($urandom); while (known_fn(fn));
        w = rtype(rs, rt, w[15:11], w[10:6], fn);
      end else begin
        do op = 6'($urandom); while (known_op(op));
        w[31:26] = op;
      end
    end
    issue(sanitize(w), $urandom);
  endtask

  initial begin
    repeat ($urandom_range(1, 3)) @(posedge clk_i);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (300) @(posedge clk_i);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk_i);
      end
    end
  end

  initial begin
    logic [31:0] text_set[5];
    logic [31:0] data_set[5];
    logic [31:0] word;
    text_set = '{mse_pkg::TextBaseReset, 32'h0, 32'hffff_fffc, $urandom, $urandom};
    data_set = '{mse_pkg::DataBaseReset, 32'h0, 32'hffff_ffff, 32'hffff_f000, $urandom};
    repeat (7) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);
    cfg_write(mse_pkg::CfgTextBase, text_set[0]);
    cfg_write(mse_pkg::CfgDataBase, data_set[0]);
    cfg_write(CfgUnused, $urandom);
    point_base(data_set[0]);
    for (int k = 0; k < 64; k++) begin
      word = $urandom;
      issue(itype(mse_pkg::OpLui, 5'd0, 5'd8, word[31:16]), $urandom);
      issue(itype(mse_pkg::OpOri, 5'd8, 5'd8, word[15:0]), $urandom);
      issue(itype(mse_pkg::OpSw, BaseReg, 5'd8, 16'(4 * k)), $urandom);
    end

    // Operand extremes, most operations and the corner cases of memory,
    // control flow and the syscall services.
    issue(itype(mse_pkg::OpLui, 5'd0, 5'd8, 16'h8000), $urandom);
    issue(itype(mse_pkg::OpAddiu, 5'd0, 5'd9, 16'hffff), $urandom);
    issue(rtype(5'd8, 5'd9, 5'd10, 5'd0, mse_pkg::FnAdd), $urandom);
    issue(rtype(5'd8, 5'd8, 5'd10, 5'd0, mse_pkg::FnAddu), $urandom);
    issue(rtype(5'd8, 5'd9, 5'd10, 5'd0, mse_pkg::FnSub), $urandom);
    issue(rtype(5'd8, 5'd9, 5'd10, 5'd0, mse_pkg::FnSlt), $urandom);
    issue(rtype(5'd9, 5'd8, 5'd0, 5'd0, mse_pkg::FnXor), $urandom);
    issue(rtype(5'd0, 5'd9, 5'd11, 5'd31, mse_pkg::FnSll), $urandom);
    issue(rtype(5'd0, 5'd9, 5'd11, 5'd31, mse_pkg::FnSrl), $urandom);
    issue(itype(mse_pkg::OpAddi, 5'd8, 5'd12, 16'h7fff), $urandom);
    issue(itype(mse_pkg::OpSlti, 5'd8, 5'd12, 16'h8000), $urandom);
    issue(itype(mse_pkg::OpXori, 5'd9, 5'd12, 16'hffff), $urandom);
    issue(itype(mse_pkg::OpSw, BaseReg, 5'd8, 16'd8189), $urandom);
    issue(itype(mse_pkg::OpLw, BaseReg, 5'd13, 16'hfffc), $urandom);
    issue(itype(mse_pkg::OpLh, BaseReg, 5'd13, 16'd1), $urandom);
    issue(itype(mse_pkg::OpLb, BaseReg, 5'd13, 16'd255), $urandom);
    issue(itype(mse_pkg::OpSh, BaseReg, 5'd9, 16'd8190), $urandom);
    issue(itype(mse_pkg::OpBeq, 5'd0, 5'd0, 16'hffff), $urandom);
    issue(itype(mse_pkg::OpBne, 5'd8, 5'd9, 16'h7fff), $urandom);
    issue({mse_pkg::OpJal, 26'h3ff_ffff}, $urandom);
    issue(rtype(mse_pkg::RegRa, 5'd0, 5'd0, 5'd0, mse_pkg::FnJr), $urandom);
    issue(itype(mse_pkg::OpAddiu, 5'd0, mse_pkg::RegV0, mse_pkg::SvcReadInt[15:0]), $urandom);
    issue(rtype(5'd0, 5'd0, 5'd0, 5'd0, mse_pkg::FnSyscall), 32'h8000_0000);
    issue(itype(mse_pkg::OpAddiu, 5'd0, mse_pkg::RegV0, mse_pkg::SvcPrintInt[15:0]), $urandom);
    issue(rtype(5'd0, 5'd0, 5'd0, 5'd0, mse_pkg::FnSyscall), $urandom);
    issue({OpUnusedTop, 26'h3ff_ffff}, $urandom);

    for (int s = 0; s < 5; s++) begin
      if (s > 0) begin
        settle();
        cfg_write(mse_pkg::CfgTextBase, text_set[s]);
        cfg_write(mse_pkg::CfgDataBase, data_set[s]);
        point_base(data_set[s]);
      end
      if (s == 1) hold_req = 1'b1;
      if (s == 4) calm = 1'b1;
      settings_run++;
      for (int n = 0; n < 220; n++) random_op();
    end

    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (10) @(posedge clk_i);
    $display("Executed %0d instructions under %0d base-address settings, covering ALU, shifts,",
             results, settings_run);
    $display("branches, jumps, syscalls, in- and out-of-range memory and unknown encodings.");
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
